// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the range marker table modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants for the range marker table.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 7;
    localparam int FIELD_W = 32;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_KILL   = 3'd1,
        OP_SEARCH = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Per-entry findings reported by the edit unit as an entry leaves it.
    typedef struct packed {
        logic valid;      // a real table entry, not a pipeline filler slot
        logic live;       // entry in use with a nonzero start after the edit
        logic match;      // entry in use equal to the searched range
        logic kill_dead;  // entry is the kill target and was already dead
    } t_scan;

endpackage

// File: src/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell
// One table slot: holds a (start, length) pair and takes its neighbor's
// pair on every shift.
// ----------------------------------------------------------------------------
module rmt_cell #(
    parameter int POSITION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  logic [POSITION_BITS-1:0] i_start,
    input  logic [POSITION_BITS-1:0] i_length,
    output logic [POSITION_BITS-1:0] o_start,
    output logic [POSITION_BITS-1:0] o_length
);

    logic [POSITION_BITS-1:0] r_start;
    logic [POSITION_BITS-1:0] r_length;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_start  <= i_start;
            r_length <= i_length;
        end
    end

    assign o_start  = r_start;
    assign o_length = r_length;

endmodule

// File: src/rmt_edit.sv
// ----------------------------------------------------------------------------
// rmt_edit
// Two-stage edit unit at the head of the cell ring: applies append, kill,
// insert and delete to the entry passing through and reports what it saw.
// ----------------------------------------------------------------------------
module rmt_edit
    import rmt_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_shift,
    input  logic                                  i_load_valid,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_tag,
    input  t_op                                   i_op,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      i_used,
    input  logic                                  i_kill_ok,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_kill_tag,
    input  logic [POSITION_BITS-1:0]              i_at,
    input  logic [POSITION_BITS-1:0]              i_amt,
    input  logic [POSITION_BITS-1:0]              i_start,
    input  logic [POSITION_BITS-1:0]              i_length,
    output logic [POSITION_BITS-1:0]              o_start,
    output logic [POSITION_BITS-1:0]              o_length,
    output t_scan                                 o_scan,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_tag
);

    `include "assert_macros.svh"

    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = POSITION_BITS;

    // stage A: first compares and adds
    logic          w_act;
    logic          w_alive;
    logic [PW-1:0] w_s1;
    logic [PW-1:0] w_gap;
    logic [PW-1:0] w_end_m1;

    logic          r_a_valid;
    logic [TW-1:0] r_a_tag;
    logic          r_a_act;
    logic          r_a_alive;
    logic [PW-1:0] r_a_start;
    logic [PW-1:0] r_a_length;
    logic [PW-1:0] r_a_s1;
    logic [PW-1:0] r_a_gap;
    logic          r_a_le;
    logic          r_a_mid;

    // stage B: finish the edit
    logic [PW-1:0] n_start;
    logic [PW-1:0] n_length;
    logic [PW-1:0] w_s1_end_m1;
    logic [PW-1:0] w_tail;
    logic [PW:0]   w_gap_len;

    logic          r_b_valid;
    logic [PW-1:0] r_b_start;
    logic [PW-1:0] r_b_length;

    assign w_act    = UW'(i_tag) < i_used;
    assign w_alive  = (i_start != '0) && (i_length != '0);
    assign w_s1     = (i_at < i_start) ? (i_start + i_amt) : i_start;
    assign w_gap    = i_start - i_at;
    assign w_end_m1 = i_start + i_length - PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_shift) begin
            r_a_valid <= i_load_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_a_tag    <= i_tag;
            r_a_act    <= w_act;
            r_a_alive  <= w_alive;
            r_a_start  <= i_start;
            r_a_length <= i_length;
            r_a_s1     <= w_s1;
            r_a_gap    <= w_gap;
            r_a_le     <= i_at <= i_start;
            r_a_mid    <= i_at < w_end_m1;
            r_b_start  <= n_start;
            r_b_length <= n_length;
        end
    end

    assign w_s1_end_m1 = r_a_s1 + r_a_length - PW'(1);
    // bytes from the delete point to the entry end: l - (at - s)
    assign w_tail      = r_a_length + r_a_gap;
    assign w_gap_len   = {1'b0, r_a_gap} + {1'b0, r_a_length};

    always_comb begin
        n_start  = r_a_start;
        n_length = r_a_length;
        case (i_op)
            OP_APPEND: begin
                if (UW'(r_a_tag) == i_used) begin
                    n_start  = i_at;
                    n_length = i_amt;
                end
            end
            OP_KILL: begin
                if (i_kill_ok && (r_a_tag == i_kill_tag)) begin
                    n_start = '0;
                end
            end
            OP_INSERT: begin
                if (r_a_act && r_a_alive) begin
                    n_start = r_a_s1;
                    if ((i_at >= r_a_s1) && (i_at < w_s1_end_m1)) begin
                        n_length = r_a_length + i_amt;
                    end
                end
            end
            OP_DELETE: begin
                if (r_a_act && r_a_alive) begin
                    priority if (r_a_le) begin
                        priority if (r_a_gap >= i_amt) begin
                            n_start = r_a_start - i_amt;
                        end else if ({1'b0, i_amt} >= w_gap_len) begin
                            n_start = '0;
                        end else begin
                            // delete eats the head: entry now begins at the cut
                            n_start  = i_at;
                            n_length = r_a_length + r_a_gap - i_amt;
                        end
                    end else if (r_a_mid) begin
                        if (i_amt >= w_tail) begin
                            n_length = PW'(0) - r_a_gap;
                        end else begin
                            n_length = r_a_length - i_amt;
                        end
                    end else begin
                        n_length = r_a_length;
                    end
                end
            end
            default: begin
                n_start  = r_a_start;
                n_length = r_a_length;
            end
        endcase
    end

    always_comb begin
        o_scan.valid     = r_a_valid;
        o_scan.live      = r_a_act && (n_start != '0);
        o_scan.match     = r_a_act && (r_a_start == i_at) && (r_a_length == i_amt);
        o_scan.kill_dead = i_kill_ok && (r_a_tag == i_kill_tag) && (r_a_start == '0);
    end

    assign o_tag    = r_a_tag;
    assign o_start  = r_b_start;
    assign o_length = r_b_length;

    `RMT_ASSERT_NXT(a_stage_b_follows, i_clk, i_rst_n, i_shift && r_a_valid, r_b_valid,
        "edit stage B lost a table entry")

endmodule

// File: src/range_marker_table.sv
// ----------------------------------------------------------------------------
// range_marker_table
// Table of (start, length) byte ranges with append, kill, search and
// insert/delete repair, built as a rotating ring of cells.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_DEPTH cells closed through a two-stage
// edit unit. Every request rotates the whole ring once, through every cell
// and both edit stages, so each entry passes the edit unit exactly once in
// index order and all entries end where they started. Append writes slot
// used_count, kill clears the numbered start and then trims dead entries off
// the tail, search reports the first matching slot, and insert/delete shift
// or resize every live slot. An accepted request runs the ring rotation, then
// waits in the done state until its result can be posted; only then does the
// block take the next request. The result sits in an output register, so
// the next request is accepted while an earlier result still waits. Request
// channel: i_in_valid/o_in_ready; result channel: o_out_valid/i_out_ready.
// Slot contents are undefined until appended; only slots below the used
// count are ever consulted.
// ----------------------------------------------------------------------------
module range_marker_table
    import rmt_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [FIELD_W-1:0] i_position,
    input  logic [FIELD_W-1:0] i_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic [IDX_W-1:0]   o_found_index,
    output logic [IDX_W-1:0]   o_used_entries
);

    `include "assert_macros.svh"

    localparam int UW         = $clog2(TABLE_DEPTH + 1);
    localparam int TW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RING_STEPS = TABLE_DEPTH + 2;
    localparam int SW         = $clog2(RING_STEPS);
    localparam int CW         = (UW > IDX_W) ? UW : IDX_W;
    localparam int PW         = POSITION_BITS;

    // control
    t_state        r_state;
    t_state        n_state;
    logic [SW-1:0] r_step;
    logic          w_shift;
    logic          w_last;
    logic          w_accept;
    logic          w_post;

    // latched request
    t_op           r_op;
    logic          r_kill_ok;
    logic [TW-1:0] r_kill_tag;
    logic [PW-1:0] r_at;
    logic [PW-1:0] r_amt;

    // table bookkeeping and scan accumulators
    logic [UW-1:0] r_used;
    logic [UW-1:0] n_used;
    logic [UW-1:0] r_found;
    logic          r_hit;
    logic [UW-1:0] r_last_live;
    logic          r_kill_dead;
    logic          n_status;
    logic [UW-1:0] n_found;

    // result register
    logic             r_out_valid;
    logic             r_status;
    logic [IDX_W-1:0] r_found_index;
    logic [IDX_W-1:0] r_used_entries;

    // ring
    logic [PW-1:0] w_cell_start  [TABLE_DEPTH];
    logic [PW-1:0] w_cell_length [TABLE_DEPTH];
    logic [PW-1:0] w_edit_start;
    logic [PW-1:0] w_edit_length;
    t_scan         w_scan;
    logic [TW-1:0] w_scan_tag;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_shift  = (r_state == ST_RUN);
    assign w_last   = (r_step == SW'(RING_STEPS - 1));
    assign w_post   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // ---------------------------------------------------------------- FSM --
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // rotate until every slot is back home
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the verdict until the result register frees up
                if (w_post) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ----------------------------------------------------- request latch --
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= t_op'(i_operation);
            r_at       <= PW'(i_position);
            r_amt      <= PW'(i_length);
            // kill number must land on a slot in use; out of range fails early
            r_kill_ok  <= (i_entry_index != '0) && (CW'(i_entry_index) <= CW'(r_used));
            r_kill_tag <= TW'(CW'(i_entry_index) - CW'(1));
        end
    end

    // -------------------------------------------- step count and scanning --
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_found     <= '0;
            r_last_live <= '0;
            r_kill_dead <= 1'b0;
        end else if (w_accept) begin
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_found     <= '0;
            r_last_live <= '0;
            r_kill_dead <= 1'b0;
        end else if (w_shift) begin
            r_step <= r_step + SW'(1);
            if (w_scan.valid) begin
                // slots come by in index order, so the last live one wins
                if (w_scan.live) begin
                    r_last_live <= UW'(w_scan_tag) + UW'(1);
                end
                // keep only the first match
                if (w_scan.match && !r_hit) begin
                    r_hit   <= 1'b1;
                    r_found <= UW'(w_scan_tag) + UW'(1);
                end
                if (w_scan.kill_dead) begin
                    r_kill_dead <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------ verdict --
    always_comb begin
        n_status = STATUS_OK;
        n_found  = '0;
        n_used   = r_used;
        case (r_op)
            OP_APPEND: begin
                if (r_used == UW'(TABLE_DEPTH)) begin
                    n_status = STATUS_FAIL;
                end else begin
                    n_used = r_used + UW'(1);
                end
            end
            OP_KILL: begin
                if (!r_kill_ok || r_kill_dead) begin
                    n_status = STATUS_FAIL;
                end else begin
                    // drop dead slots off the tail
                    n_used = r_last_live;
                end
            end
            OP_SEARCH: begin
                n_found = r_found;
            end
            OP_INSERT, OP_DELETE: begin
                n_status = STATUS_OK;
            end
            default: begin
                n_status = STATUS_FAIL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_post) begin
            r_used      <= n_used;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            r_status       <= n_status;
            r_found_index  <= IDX_W'(n_found);
            r_used_entries <= IDX_W'(n_used);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_found_index  = r_found_index;
    assign o_used_entries = r_used_entries;

    // --------------------------------------------------------------- ring --
    rmt_edit #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_edit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_shift      (w_shift),
        .i_load_valid (r_step < SW'(TABLE_DEPTH)),
        .i_tag        (TW'(r_step)),
        .i_op         (r_op),
        .i_used       (r_used),
        .i_kill_ok    (r_kill_ok),
        .i_kill_tag   (r_kill_tag),
        .i_at         (r_at),
        .i_amt        (r_amt),
        .i_start      (w_cell_start[0]),
        .i_length     (w_cell_length[0]),
        .o_start      (w_edit_start),
        .o_length     (w_edit_length),
        .o_scan       (w_scan),
        .o_tag        (w_scan_tag)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [PW-1:0] w_next_start;
        logic [PW-1:0] w_next_length;

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next_start  = w_edit_start;
            assign w_next_length = w_edit_length;
        end else begin : g_body
            assign w_next_start  = w_cell_start[g+1];
            assign w_next_length = w_cell_length[g+1];
        end

        rmt_cell #(
            .POSITION_BITS (POSITION_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_shift),
            .i_start  (w_next_start),
            .i_length (w_next_length),
            .o_start  (w_cell_start[g]),
            .o_length (w_cell_length[g])
        );
    end

    // --------------------------------------------------------- assertions --
    `RMT_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= UW'(TABLE_DEPTH),
        "used count exceeds table depth")
    `RMT_ASSERT_NXT(a_pass_ends, i_clk, i_rst_n, (r_state == ST_RUN) && w_last,
        r_state == ST_DONE, "ring pass did not end in the done state")
    `RMT_ASSERT_IMP(a_result_after_pass, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state == ST_DONE), "result posted without a finished pass")

endmodule

// File: bench/range_marker_table_test.sv
// ----------------------------------------------------------------------------
// range_marker_table_test
// Self-checking bench for the range marker table. A mirror of the table
// follows every accepted request and queues the reply it should produce; each
// reply from the block is compared field by field with the oldest queued one.
// Stimulus starts with hand-picked corner requests, then cycles the table
// through fill, drain and balanced traffic under four pacing phases, with one
// long result-side hold that backs the block up into its request port.
// ----------------------------------------------------------------------------
module range_marker_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmt_pkg::*;

    localparam int TABLE_DEPTH      = 64;
    localparam int POSITION_BITS    = 32;
    localparam int ITEMS_PER_PHASE  = 275;
    localparam int LONG_HOLD_CYCLES = 600;
    // Longest correct stretch without a handshake is the long hold plus one
    // table pass; allow several times that.
    localparam int QUIET_LIMIT      = 4000;

    // Operation codes the block does not implement; it must answer with a
    // failure and leave the table alone.
    localparam logic [OP_W-1:0]    OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0]    OP_UNUSED_HI = 3'd7;
    localparam logic [IDX_W-1:0]   IDX_MAX      = '1;
    localparam logic [FIELD_W-1:0] ALL_ONES     = '1;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] found;
        logic [IDX_W-1:0] used;
    } t_reply;

    // Traffic mix of the random part: fill the table past full, drain it
    // through kills, then run a balanced stretch.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    // ------------------------------------------------------------------------
    // Table mirror: holds its own copy of the ranges and the replies that the
    // block owes.
    // ------------------------------------------------------------------------
    class marker_table_mirror;
        logic [FIELD_W-1:0] range_start  [TABLE_DEPTH];
        logic [FIELD_W-1:0] range_length [TABLE_DEPTH];
        int                 used     = 0;
        int                 failures = 0;
        t_reply             awaited_replies [$];

        // Apply one accepted request to the mirror and queue its reply.
        function void apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                    logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] len);
            t_reply             reply;
            logic [FIELD_W-1:0] s, l, s_end, gap, rest, off, tail;
            int                 i;

            reply.status = STATUS_OK;
            reply.found  = '0;
            case (op)
                OP_APPEND: begin
                    if (used == TABLE_DEPTH) begin
                        reply.status = STATUS_FAIL;
                    end else begin
                        range_start[used]  = pos;
                        range_length[used] = len;
                        used++;
                    end
                end
                OP_KILL: begin
                    if (idx == '0 || idx > used) begin
                        reply.status = STATUS_FAIL;
                    end else if (range_start[idx - 1] == '0) begin
                        reply.status = STATUS_FAIL;
                    end else begin
                        range_start[idx - 1] = '0;
                        // Trim dead entries off the tail.
                        while (used > 0 && range_start[used - 1] == '0)
                            used--;
                    end
                end
                OP_SEARCH: begin
                    // First hit wins; dead entries compare like any other.
                    for (i = 0; i < used; i++) begin
                        if (reply.found == '0 && range_start[i] == pos &&
                            range_length[i] == len)
                            reply.found = IDX_W'(i + 1);
                    end
                end
                OP_INSERT: begin
                    for (i = 0; i < used; i++) begin
                        s = range_start[i];
                        l = range_length[i];
                        if (s != '0 && l != '0) begin
                            if (pos < s)
                                s = s + len;
                            s_end = s + l - 1'b1;
                            if (pos >= s && pos < s_end)
                                l = l + len;
                            range_start[i]  = s;
                            range_length[i] = l;
                        end
                    end
                end
                OP_DELETE: begin
                    for (i = 0; i < used; i++) begin
                        s = range_start[i];
                        l = range_length[i];
                        if (s != '0 && l != '0) begin
                            s_end = s + l - 1'b1;
                            if (pos <= s) begin
                                gap = s - pos;
                                if (gap >= len) begin
                                    s = s - len;
                                end else begin
                                    // Delete reaches into the range: only the
                                    // bytes past its start shorten it.
                                    rest = len - gap;
                                    if (rest >= l) begin
                                        s = '0;
                                    end else begin
                                        s = s - gap;
                                        l = l - rest;
                                    end
                                end
                            end else if (pos < s_end) begin
                                off  = pos - s;
                                tail = l - off;
                                if (len >= tail)
                                    l = off;
                                else
                                    l = l - len;
                            end
                            range_start[i]  = s;
                            range_length[i] = l;
                        end
                    end
                end
                default: begin
                    reply.status = STATUS_FAIL;
                end
            endcase
            reply.used = IDX_W'(used);
            awaited_replies.push_back(reply);
        endfunction

        // Compare one reply from the block with the oldest owed reply.
        function void check_reply(logic status, logic [IDX_W-1:0] found,
                                  logic [IDX_W-1:0] used_entries);
            t_reply want;

            if (awaited_replies.size() == 0) begin
                $error("reply with no request outstanding: status %0d found %0d used %0d",
                       status, found, used_entries);
                failures++;
                return;
            end
            want = awaited_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (found !== want.found) begin
                $error("found_index: expected %0d, got %0d", want.found, found);
                failures++;
            end
            if (used_entries !== want.used) begin
                $error("used_entries: expected %0d, got %0d", want.used, used_entries);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup; every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_operation   = '0;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic [FIELD_W-1:0] i_position    = '0;
    logic [FIELD_W-1:0] i_length      = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b1;
    logic               o_status;
    logic [IDX_W-1:0]   o_found_index;
    logic [IDX_W-1:0]   o_used_entries;

    marker_table_mirror mirror = new();

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    bit   hold_arm           = 1'b0;
    int   hold_left          = 0;
    int   quiet_cycles       = 0;
    t_mix mix_mode           = MIX_FILL;
    int   overfill_left      = 4;
    int   balanced_left      = 0;

    range_marker_table #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_position     (i_position),
        .i_length       (i_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_used_entries (o_used_entries)
    );

    always #5 i_clk = ~i_clk;

    // Result side: stall at the phase rate, or hold off entirely for a long
    // stretch once armed so the block backs up into its request port.
    always @(posedge i_clk) begin
        if (hold_arm) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_arm  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Check every reply taken off the result port.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            mirror.check_reply(o_status, o_found_index, o_used_entries);
    end

    // Watchdog: end the run if neither port moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("range_marker_table test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly small values so ranges overlap and searches hit; some zeros,
    // values near the top of the range, and fully random words.
    function automatic logic [FIELD_W-1:0] pick_value();
        int r;

        r = $urandom_range(99);
        if (r < 60)
            return FIELD_W'($urandom_range(300, 1));
        else if (r < 70)
            return '0;
        else if (r < 78)
            return ALL_ONES;
        else if (r < 85)
            return ALL_ONES - FIELD_W'($urandom_range(300));
        return FIELD_W'($urandom);
    endfunction

    // Offer one request after a random idle gap; hold it until accepted,
    // then hand it to the mirror.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [FIELD_W-1:0] pos,
                                input logic [FIELD_W-1:0] len);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_position    <= pos;
        i_length      <= len;
        do @(posedge i_clk); while (!o_in_ready);
        mirror.apply_request(op, idx, pos, len);
    endtask

    // One pacing phase of random traffic. Requests with unknown codes are
    // sent too but do not count toward the phase length.
    task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
        int                 sent;
        int                 r;
        int                 pick;
        int                 cut_append, cut_kill, cut_search, cut_insert;
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] pos, len;

        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        if (long_hold)
            hold_arm = 1'b1;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            // Advance the traffic mix from the mirror's fill level.
            case (mix_mode)
                MIX_FILL: begin
                    if (mirror.used == TABLE_DEPTH) begin
                        if (overfill_left == 0)
                            mix_mode = MIX_DRAIN;
                        else
                            overfill_left--;
                    end
                end
                MIX_DRAIN: begin
                    if (mirror.used <= 4) begin
                        mix_mode      = MIX_BALANCED;
                        balanced_left = $urandom_range(80, 20);
                    end
                end
                default: begin
                    if (balanced_left == 0) begin
                        mix_mode      = MIX_FILL;
                        overfill_left = $urandom_range(6, 2);
                    end else begin
                        balanced_left--;
                    end
                end
            endcase
            case (mix_mode)
                MIX_FILL: begin
                    cut_append = 70; cut_kill = 76; cut_search = 88; cut_insert = 94;
                end
                MIX_DRAIN: begin
                    cut_append = 10; cut_kill = 60; cut_search = 75; cut_insert = 85;
                end
                default: begin
                    cut_append = 30; cut_kill = 50; cut_search = 70; cut_insert = 85;
                end
            endcase

            idx  = IDX_W'($urandom_range(IDX_MAX));
            pos  = pick_value();
            len  = pick_value();
            r    = $urandom_range(99);
            pick = $urandom_range(9);
            if (r < 3)
                op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            else if (r < cut_append)
                op = OP_APPEND;
            else if (r < cut_kill)
                op = OP_KILL;
            else if (r < cut_search)
                op = OP_SEARCH;
            else if (r < cut_insert)
                op = OP_INSERT;
            else
                op = OP_DELETE;

            case (op)
                OP_KILL: begin
                    // Favor the tail so kills trim; keep some bad numbers.
                    if (pick < 5)
                        idx = IDX_W'(mirror.used);
                    else if (pick < 8)
                        idx = IDX_W'($urandom_range(mirror.used > 0 ? mirror.used : 1, 1));
                    else if (pick < 9)
                        idx = '0;
                end
                OP_SEARCH: begin
                    // Mostly look up a range that is in the table right now.
                    if (pick < 6 && mirror.used > 0) begin
                        r   = $urandom_range(mirror.used - 1);
                        pos = mirror.range_start[r];
                        len = mirror.range_length[r];
                    end else if (pick < 7) begin
                        pos = '0;
                    end
                end
                OP_INSERT, OP_DELETE: begin
                    if (pick < 7)
                        len = FIELD_W'($urandom_range(64, 1));
                end
                default: ;
            endcase

            send_request(op, idx, pos, len);
            if (op <= OP_DELETE)
                sent++;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, no idling.
        send_request(OP_SEARCH, '0, '0, '0);              // search an empty table
        send_request(OP_KILL, 7'd1, '0, '0);              // kill with nothing in use
        send_request(OP_APPEND, '0, 32'd1, 32'd10);
        send_request(OP_APPEND, '0, '0, 32'd5);            // start zero: dead but used
        send_request(OP_APPEND, '0, ALL_ONES, ALL_ONES);
        send_request(OP_APPEND, '0, 32'd100, '0);          // zero length
        send_request(OP_APPEND, IDX_MAX, 32'd50, 32'd20);
        send_request(OP_SEARCH, '0, '0, 32'd5);            // matches the dead entry
        send_request(OP_SEARCH, IDX_MAX, 32'd50, 32'd20);
        send_request(OP_SEARCH, '0, ALL_ONES, ALL_ONES);
        send_request(OP_KILL, '0, '0, '0);                 // number zero
        send_request(OP_KILL, 7'd6, '0, '0);               // past the used count
        send_request(OP_KILL, IDX_MAX, ALL_ONES, ALL_ONES);
        send_request(OP_KILL, 7'd2, '0, '0);               // already dead
        send_request(OP_INSERT, '0, 32'd55, 32'd3);         // grows the range at 50
        send_request(OP_INSERT, '0, '0, 32'd1);             // shifts every live range up by one
        send_request(OP_DELETE, '0, 32'd40, 32'd15);        // overlaps a start
        send_request(OP_DELETE, '0, '0, '0);
        send_request(OP_DELETE, '0, 32'd45, ALL_ONES);      // cuts a range tail
        send_request(OP_UNUSED_LO, IDX_MAX, ALL_ONES, ALL_ONES);
        send_request(OP_UNUSED_LO + 3'd1, '0, '0, '0);
        send_request(OP_UNUSED_HI, 7'd1, 32'd1, 32'd1);
        send_request(OP_DELETE, 7'd1, 32'd1, ALL_ONES);     // kills all but one live range
        send_request(OP_KILL, 7'd1, '0, '0);
        send_request(OP_APPEND, '0, ALL_ONES, '0);

        // Random traffic: free running with one long result hold, then
        // sender gaps, result stalls, and both at a lighter rate.
        run_phase(0, 0, 1'b1);
        run_phase(49, 0, 1'b0);
        run_phase(0, 49, 1'b0);
        run_phase(14, 14, 1'b0);

        // Drain: drop valid, wait for every owed reply, then let a table
        // pass go by to catch stray replies.
        i_in_valid <= 1'b0;
        while (mirror.awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (mirror.failures == 0 && mirror.awaited_replies.size() == 0)
            $display("range_marker_table test passed");
        else
            $display("range_marker_table test failed");
        $finish;
    end

endmodule
